// ===== rtl/ara_pkg.sv =====
// Shared types and constants for the address range allocator.
// Used by ara_table and address_range_allocator; no other dependencies.
package ara_pkg;

  localparam int unsigned PAGE_NUM_BITS = 36;
  localparam int unsigned PN_W = PAGE_NUM_BITS;
  localparam int unsigned SZ_W = 37;
  localparam int unsigned GAP_LIMIT = 1024;

  localparam logic CFG_SPACE_BASE = 1'b0;
  localparam logic CFG_SPACE_SIZE = 1'b1;

  typedef enum logic [1:0] {
    OP_PLACE = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FIND  = 2'd2,
    OP_FREE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } result_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_ALLOC_RD,
    S_ALLOC,
    S_ALLOC_AL,
    S_SHIFT_RD,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

// ===== rtl/ara_table.sv =====
// Range table memory: start and length arrays, one write and one read port.
// Depends on ara_pkg for field widths.
module ara_table #(
  parameter int unsigned MAX_RANGES = 64,
  parameter int unsigned IDX_W = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [IDX_W-1:0]         waddr,
  input  logic [ara_pkg::PN_W-1:0] wstart,
  input  logic [ara_pkg::SZ_W-1:0] wlen,
  input  logic [IDX_W-1:0]         raddr,
  output logic [ara_pkg::PN_W-1:0] rstart,
  output logic [ara_pkg::SZ_W-1:0] rlen
);

  logic [ara_pkg::PN_W-1:0] mem_start [MAX_RANGES];
  logic [ara_pkg::SZ_W-1:0] mem_len [MAX_RANGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_start[waddr] <= wstart;
      mem_len[waddr] <= wlen;
    end
    rstart <= mem_start[raddr];
    rlen <= mem_len[raddr];
  end

endmodule

// ===== rtl/address_range_allocator.sv =====
// Address range allocator top level: sequencer, compare logic and
// the range table. Depends on ara_pkg and ara_table.
//
// Usage: drive op, addr_page, size_pages, align_log2 and min_gap_pages with
// start high while busy is low; that word is taken at the clock edge. busy
// stays high until the result word appears on status, base_page and
// range_pages with done high for exactly one cycle. The receiver cannot
// stall; the result must be taken in that cycle.
// Sequence: place, find and free scan the sorted table through the single
// registered read port, with a read state and a compare state per entry.
// A place, allocate or free then moves the entries above the slot one at a
// time, and allocate passes through its read, compare and align states on
// each gap it tries. A new word is taken from the cycle after the
// result cycle. Configuration writes (cfg_we, cfg_index, cfg_data) must
// only be made while busy is low. Reset clears the entry count and sets the
// window to the whole page space; the table contents are not cleared and
// need no clearing pass.
module address_range_allocator #(
  parameter int unsigned MAX_RANGES = 64,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [35:0] addr_page,
  input  logic [36:0] size_pages,
  input  logic [5:0]  align_log2,
  input  logic [10:0] min_gap_pages,
  output logic        done,
  output logic [2:0]  status,
  output logic [35:0] base_page,
  output logic [36:0] range_pages,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [36:0] cfg_data
);

  localparam int unsigned IDX_W = $clog2(MAX_RANGES);
  localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);
  localparam int unsigned PW = ara_pkg::PN_W;
  localparam int unsigned SW = ara_pkg::SZ_W;
  localparam int unsigned XW = SW + 2;
  localparam logic [XW-1:0] PAGE_TOP =
    XW'((XW'(1) << ara_pkg::PAGE_NUM_BITS) - XW'(1));

  ara_pkg::state_t state, state_next;

  logic [PW-1:0] win_base;
  logic [SW-1:0] win_size;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] slot;
  ara_pkg::op_t opr;
  logic [PW-1:0] addr_r;
  logic [SW-1:0] n_r;
  logic [5:0] sh_r;
  logic [10:0] gap_r;
  logic [XW-1:0] gb_r;
  logic [XW-1:0] ge_r;
  logic found;
  logic [PW-1:0] fstart;
  logic [SW-1:0] flen;
  logic [2:0] st_r;
  logic [PW-1:0] ob_r;
  logic [SW-1:0] on_r;
  logic [CNT_W-1:0] idx_found;
  logic [CNT_W-1:0] idx_found_next;
  logic ob_fin_hold;

  logic tbl_we;
  logic [IDX_W-1:0] tbl_waddr, tbl_raddr;
  logic [PW-1:0] tbl_wstart, rstart;
  logic [SW-1:0] tbl_wlen, rlen;
  logic [PW-1:0] mv_start;
  logic [SW-1:0] mv_len;

  ara_table #(.MAX_RANGES(MAX_RANGES), .IDX_W(IDX_W)) u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wstart(tbl_wstart), .wlen(tbl_wlen),
    .raddr(tbl_raddr), .rstart(rstart), .rlen(rlen)
  );

  logic [XW-1:0] wl;
  logic [XW-1:0] place_end;
  logic [XW-1:0] align_m;
  logic [XW-1:0] pva;
  always_comb begin
    logic [XW-1:0] s;
    logic [XW-1:0] l;
    s = (win_size == '0) ? XW'(1) : XW'(win_size);
    l = XW'(win_base) + s - XW'(1);
    wl = (l > PAGE_TOP) ? PAGE_TOP : l;
    place_end = XW'(addr_r) + XW'(n_r) - XW'(1);
    align_m = (XW'(1) << sh_r) - XW'(1);
    pva = (gb_r + align_m) & ~align_m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_base <= '0;
      win_size <= SW'(1) << 36;
    end else if (cfg_we) begin
      if (cfg_index == ara_pkg::CFG_SPACE_BASE) win_base <= cfg_data[PW-1:0];
      else win_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ara_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic go_ins, go_del, fin;
  logic [2:0] fin_st;
  logic [PW-1:0] fin_b;
  logic [SW-1:0] fin_n;
  logic gb_upd, ge_upd, fnd_upd, next_idx;
  logic [XW-1:0] gb_new, ge_new;

  always_comb begin
    logic [XW-1:0] cand;
    logic [XW-1:0] ns;
    state_next = state;
    go_ins = 1'b0;
    go_del = 1'b0;
    fin = 1'b0;
    fin_st = ara_pkg::ST_OK;
    fin_b = '0;
    fin_n = '0;
    gb_upd = 1'b0;
    ge_upd = 1'b0;
    fnd_upd = 1'b0;
    next_idx = 1'b0;
    gb_new = gb_r;
    ge_new = ge_r;
    cand = '0;
    ns = '0;
    tbl_raddr = idx[IDX_W-1:0];
    case (state)
      ara_pkg::S_IDLE: begin
        if (start) begin
          state_next = (ara_pkg::op_t'(op) == ara_pkg::OP_ALLOC) ? ara_pkg::S_ALLOC_RD
                                                                   : ara_pkg::S_SCAN_RD;
        end
      end
      ara_pkg::S_SCAN_RD: begin
        if (opr == ara_pkg::OP_PLACE && (n_r == '0 || addr_r < win_base ||
            XW'(addr_r) > wl || place_end > PAGE_TOP || place_end > wl)) begin
          fin = 1'b1;
          fin_st = ara_pkg::ST_RANGE;
        end else if (idx >= count) begin
          fin = 1'b1;
          if (opr == ara_pkg::OP_PLACE) begin
            if (found && XW'(fstart) + XW'(flen) - XW'(1) >= XW'(addr_r)) begin
              fin_st = ara_pkg::ST_NOSPACE;
            end else if (count >= CNT_W'(MAX_RANGES)) begin
              fin_st = ara_pkg::ST_FULL;
            end else begin
              fin = 1'b0;
              go_ins = 1'b1;
            end
          end else if (!found || XW'(addr_r) > XW'(fstart) + XW'(flen) - XW'(1)) begin
            fin_st = ara_pkg::ST_NOTFOUND;
          end else begin
            fin_b = fstart;
            fin_n = flen;
            if (opr == ara_pkg::OP_FREE) begin
              fin = 1'b0;
              go_del = 1'b1;
            end
          end
        end else begin
          state_next = ara_pkg::S_SCAN;
        end
      end
      ara_pkg::S_SCAN: begin
        ns = (opr == ara_pkg::OP_PLACE) ? place_end : XW'(addr_r);
        if (XW'(rstart) <= ns) begin
          fnd_upd = 1'b1;
          next_idx = 1'b1;
          state_next = ara_pkg::S_SCAN_RD;
        end else begin
          state_next = ara_pkg::S_SCAN_RD;
          next_idx = 1'b1;
          fnd_upd = 1'b0;
        end
      end
      ara_pkg::S_ALLOC_RD: begin
        if (n_r == '0) begin
          fin = 1'b1;
          fin_st = ara_pkg::ST_RANGE;
        end else if (count >= CNT_W'(MAX_RANGES)) begin
          fin = 1'b1;
          fin_st = ara_pkg::ST_FULL;
        end else if (gb_r > PAGE_TOP) begin
          fin = 1'b1;
          fin_st = ara_pkg::ST_NOSPACE;
        end else if (idx >= count) begin
          if (gb_r == wl + XW'(1)) begin
            fin = 1'b1;
            fin_st = ara_pkg::ST_NOSPACE;
          end else begin
            ge_upd = 1'b1;
            ge_new = wl;
            state_next = ara_pkg::S_ALLOC_AL;
          end
        end else begin
          state_next = ara_pkg::S_ALLOC;
        end
      end
      ara_pkg::S_ALLOC: begin
        ns = XW'(rstart);
        cand = ns + XW'(rlen) + XW'(gap_r);
        if (gb_r == ns) begin
          gb_upd = 1'b1;
          gb_new = cand;
          next_idx = 1'b1;
          state_next = ara_pkg::S_ALLOC_RD;
        end else if (ns <= XW'(gap_r)) begin
          fin = 1'b1;
          fin_st = ara_pkg::ST_NOSPACE;
        end else begin
          ge_upd = 1'b1;
          ge_new = ns - XW'(gap_r) - XW'(1);
          state_next = ara_pkg::S_ALLOC_AL;
        end
      end
      ara_pkg::S_ALLOC_AL: begin
        if (ge_r < XW'(addr_r)) begin
          state_next = ara_pkg::S_ALLOC_RD;
        end else if (gb_r < XW'(addr_r)) begin
          gb_upd = 1'b1;
          gb_new = XW'(addr_r);
        end else if (sh_r >= 6'(ara_pkg::PAGE_NUM_BITS)) begin
          if (gb_r != '0) begin
            fin = 1'b1;
            fin_st = ara_pkg::ST_NOSPACE;
          end else if (ge_r + XW'(1) >= XW'(n_r)) begin
            go_ins = 1'b1;
          end else begin
            state_next = ara_pkg::S_ALLOC_RD;
          end
        end else if (pva > PAGE_TOP) begin
          fin = 1'b1;
          fin_st = ara_pkg::ST_NOSPACE;
        end else if (pva <= ge_r && ge_r - pva + XW'(1) >= XW'(n_r)) begin
          gb_upd = 1'b1;
          gb_new = pva;
          go_ins = 1'b1;
        end else begin
          state_next = ara_pkg::S_ALLOC_RD;
        end
        if (state_next == ara_pkg::S_ALLOC_RD) begin
          if (idx >= count) begin
            fin = 1'b1;
            fin_st = ara_pkg::ST_NOSPACE;
            state_next = ara_pkg::S_ALLOC_AL;
          end else begin
            gb_upd = 1'b1;
            gb_new = XW'(rstart) + XW'(rlen) + XW'(gap_r);
            next_idx = 1'b1;
          end
        end
      end
      ara_pkg::S_SHIFT_RD: begin
        if (opr == ara_pkg::OP_FREE) begin
          tbl_raddr = IDX_W'(idx + CNT_W'(1));
          if (idx + CNT_W'(1) >= count) begin
            fin = 1'b1;
            fin_b = ob_r;
            fin_n = on_r;
          end else begin
            state_next = ara_pkg::S_SHIFT;
          end
        end else begin
          tbl_raddr = IDX_W'(idx - CNT_W'(1));
          if (idx == slot) begin
            fin = 1'b1;
            fin_b = ob_r;
            fin_n = on_r;
          end else begin
            state_next = ara_pkg::S_SHIFT;
          end
        end
      end
      ara_pkg::S_SHIFT: begin
        state_next = ara_pkg::S_SHIFT_RD;
      end
      ara_pkg::S_DONE: begin
        state_next = ara_pkg::S_IDLE;
      end
      default: begin
        state_next = ara_pkg::S_IDLE;
      end
    endcase
    if (fin) state_next = ara_pkg::S_DONE;
    if (go_ins || go_del) state_next = ara_pkg::S_SHIFT_RD;
  end

  assign mv_start = rstart;
  assign mv_len = rlen;

  always_comb begin
    tbl_we = 1'b0;
    tbl_waddr = idx[IDX_W-1:0];
    tbl_wstart = mv_start;
    tbl_wlen = mv_len;
    if (state == ara_pkg::S_SHIFT) begin
      tbl_we = 1'b1;
    end else if (state == ara_pkg::S_SHIFT_RD && opr != ara_pkg::OP_FREE && idx == slot) begin
      tbl_we = 1'b1;
      tbl_wstart = ob_r;
      tbl_wlen = on_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= fin;
      if (state == ara_pkg::S_SHIFT_RD && fin) begin
        if (opr == ara_pkg::OP_FREE) count <= count - CNT_W'(1);
        else count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ara_pkg::S_IDLE && start) begin
      opr <= ara_pkg::op_t'(op);
      addr_r <= addr_page;
      n_r <= size_pages;
      sh_r <= (align_log2 < 6'(PAGE_SHIFT)) ? 6'd0 : align_log2 - 6'(PAGE_SHIFT);
      gap_r <= (min_gap_pages > 11'(ara_pkg::GAP_LIMIT)) ? 11'(ara_pkg::GAP_LIMIT)
                                                         : min_gap_pages;
      gb_r <= XW'(win_base);
      ge_r <= '0;
      idx <= '0;
      found <= 1'b0;
    end else begin
      if (gb_upd) gb_r <= gb_new;
      if (ge_upd) ge_r <= ge_new;
      if (fnd_upd) begin
        found <= 1'b1;
        fstart <= rstart;
        flen <= rlen;
      end
      if (next_idx) idx <= idx + CNT_W'(1);
      if (go_ins) begin
        ob_r <= (opr == ara_pkg::OP_ALLOC) ? gb_new[PW-1:0] : addr_r;
        on_r <= n_r;
        slot <= (opr == ara_pkg::OP_ALLOC) ? idx : (found ? idx_found_next : '0);
        idx <= count;
      end
      if (go_del) begin
        ob_r <= fin_b;
        on_r <= fin_n;
        idx <= idx_found;
      end
      if (state == ara_pkg::S_SHIFT) begin
        if (opr == ara_pkg::OP_FREE) idx <= idx + CNT_W'(1);
        else idx <= idx - CNT_W'(1);
      end
    end
    if (fin) begin
      st_r <= fin_st;
      ob_r <= fin_b;
      on_r <= fin_n;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ara_pkg::S_IDLE) begin
      idx_found <= '0;
    end else if (fnd_upd) begin
      idx_found <= idx;
    end
  end
  assign idx_found_next = idx_found + CNT_W'(1);

  assign busy = (state != ara_pkg::S_IDLE);
  assign status = st_r;
  assign base_page = (st_r == ara_pkg::ST_OK) ? ob_r : '0;
  assign range_pages = (st_r == ara_pkg::ST_OK) ? on_r : '0;

  always_ff @(posedge clk) begin
    if (fin) begin
      ob_fin_hold <= 1'b1;
    end else begin
      ob_fin_hold <= 1'b0;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RANGES)) else $error("entry count above table depth");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    ob_fin_hold |-> done) else $error("result strobe without completion");

endmodule
